// ===== hdl/fmdwg_pkg.sv =====
// Shared types and constants for the four-mode DAC waveform generator.
// No dependencies; imported by every module of the block.
package fmdwg_pkg;

	localparam int CODE_BITS = 12;
	localparam int PROD_BITS = 2 * CODE_BITS;
	localparam int WORD_BITS = 14;

	localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] CTRL_BITS = 14'h3000;

	localparam logic [CODE_BITS-1:0] STEP_RESET = 12'd74;
	localparam logic [CODE_BITS-1:0] PEAK_RESET = 12'd1480;
	localparam logic [CODE_BITS-1:0] FALL_RESET = 12'd20;

	typedef enum logic [1:0] {
		MODE_DC     = 2'd0,
		MODE_SQUARE = 2'd1,
		MODE_SAW    = 2'd2,
		MODE_TRI    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_STEP = 2'd1,
		REG_PEAK = 2'd2,
		REG_FALL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		mode_t                mode;
		logic [CODE_BITS-1:0] step;
		logic [CODE_BITS-1:0] peak;
		logic [CODE_BITS-1:0] fall;
	} cfg_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] up;
		logic [CODE_BITS-1:0] down;
		logic                 rising;
	} wave_state_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 falling;
	} result_t;

endpackage

// ===== hdl/fmdwg_regs.sv =====
// Configuration register file of the waveform generator.
// Depends on fmdwg_pkg for the register map and reset values.
module fmdwg_regs
	import fmdwg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CODE_BITS-1:0] cfg_wdata,
	output cfg_t                 cfg,
	output logic                 clear
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx   = reg_idx_t'(cfg_index);
	assign cfg   = cfg_q;
	// a mode write restarts the waveform
	assign clear = cfg_we && (idx == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_DC;
			cfg_q.step <= STEP_RESET;
			cfg_q.peak <= PEAK_RESET;
			cfg_q.fall <= FALL_RESET;
		end else if (cfg_we) begin
			unique case (idx)
				REG_MODE: cfg_q.mode <= mode_t'(cfg_wdata[1:0]);
				REG_STEP: cfg_q.step <= cfg_wdata;
				REG_PEAK: cfg_q.peak <= cfg_wdata;
				REG_FALL: cfg_q.fall <= cfg_wdata;
				default:  cfg_q.mode <= cfg_q.mode;
			endcase
		end
	end

endmodule

// ===== hdl/fmdwg_wave.sv =====
// Per-word waveform logic: counter update, one multiply-compare, mode select.
// Purely combinational; depends on fmdwg_pkg.
module fmdwg_wave
	import fmdwg_pkg::*;
(
	input  cfg_t                 cfg,
	input  wave_state_t          cur,
	input  logic                 tick,
	input  logic [CODE_BITS-1:0] level,
	output wave_state_t          nxt,
	output result_t              res
);

	logic [CODE_BITS-1:0] up_inc;
	logic [CODE_BITS-1:0] dn_dec;
	logic [CODE_BITS-1:0] mul_op;
	logic [PROD_BITS-1:0] prod;
	logic                 at_peak;
	logic [CODE_BITS-1:0] clipped;
	logic                 tri_fall;

	assign tri_fall = (cfg.mode == MODE_TRI) && !cur.rising;
	assign up_inc   = tick ? cur.up + 1'b1 : cur.up;
	assign dn_dec   = (tick && tri_fall && (cur.down != '0)) ? cur.down - 1'b1 : cur.down;

	// one multiplier, shared by the rising and falling ramps
	assign mul_op  = tri_fall ? dn_dec : up_inc;
	assign prod    = PROD_BITS'(mul_op) * PROD_BITS'(cfg.step);
	assign at_peak = prod >= PROD_BITS'(cfg.peak);
	assign clipped = (prod > PROD_BITS'(CODE_MAX)) ? CODE_MAX : prod[CODE_BITS-1:0];

	always_comb begin
		nxt.up      = up_inc;
		nxt.down    = dn_dec;
		nxt.rising  = cur.rising;
		res.code    = '0;
		res.falling = 1'b0;
		case (cfg.mode)
			MODE_DC: begin
				res.code = level;
			end
			MODE_SQUARE: begin
				res.code = up_inc[0] ? level : '0;
			end
			MODE_SAW: begin
				if (at_peak) begin
					nxt.up = '0;
				end else begin
					res.code = clipped;
				end
			end
			MODE_TRI: begin
				if (cur.rising) begin
					res.code = clipped;
					if (at_peak) begin
						nxt.rising = 1'b0;
						nxt.up     = '0;
						nxt.down   = cfg.fall;
					end
				end else begin
					res.falling = 1'b1;
					if (prod == '0) begin
						nxt.rising = 1'b1;
						nxt.up     = '0;
					end else begin
						res.code = clipped;
					end
				end
			end
			default: begin
				res.code = level;
			end
		endcase
	end

endmodule

// ===== hdl/four_mode_dac_waveform_generator.sv =====
// Four-mode DAC waveform generator, top level: input register, waveform state,
// result register. Depends on fmdwg_pkg, fmdwg_regs and fmdwg_wave.
//
// One word in, one DAC code out. Each input word (tick, level) is taken into
// an input register; when the result register is free, the waveform logic
// advances the counters, forms the code for the selected mode (dc, square,
// sawtooth, triangle) with a single 12x12 multiply and peak compare, and
// loads the result register, which drives out_valid. A new word can be taken
// every cycle unless in_stall is high: the throughput is one word per clock,
// set by the one multiply-compare stage that also updates the counters.
// in_stall rises only when the input register holds a word and the result
// register is full and stalled. dac_word is the converter command: control
// bits 0x3000 or'ed with sample_code. falling flags codes of the triangle's
// falling phase. Writing the mode register (index 0) restarts the waveform;
// the user must write registers only while the block is idle; the block
// itself does not enforce this.
module four_mode_dac_waveform_generator
	import fmdwg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 tick,
	input  logic [CODE_BITS-1:0] level,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_BITS-1:0] sample_code,
	output logic [WORD_BITS-1:0] dac_word,
	output logic                 falling,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CODE_BITS-1:0] cfg_wdata
);

	cfg_t                 cfg;
	logic                 cfg_clear;

	logic                 valid_s1;
	logic                 tick_s1;
	logic [CODE_BITS-1:0] level_s1;
	logic                 valid_s2;
	result_t              res_s2;

	wave_state_t          state_q;
	wave_state_t          state_nxt;
	result_t              res_nxt;

	logic                 in_accept;
	logic                 out_free;
	logic                 advance;

	fmdwg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.clear     (cfg_clear)
	);

	fmdwg_wave u_wave (
		.cfg   (cfg),
		.cur   (state_q),
		.tick  (tick_s1),
		.level (level_s1),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// handshake: result register frees when empty or being drained
	assign out_free  = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_s1  <= tick;
			level_s1 <= level;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	// waveform state moves once per word that reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.up     <= '0;
			state_q.down   <= '0;
			state_q.rising <= 1'b1;
		end else if (cfg_clear) begin
			state_q.up     <= '0;
			state_q.down   <= '0;
			state_q.rising <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign sample_code = res_s2.code;
	assign dac_word    = CTRL_BITS | WORD_BITS'(res_s2.code);
	assign falling     = res_s2.falling;

endmodule

// ===== hdl/fmdwg_checker.sv =====
// Port-level checks for the four-mode DAC waveform generator, bound to the top.
// Depends on fmdwg_pkg and four_mode_dac_waveform_generator.
module fmdwg_checker
	import fmdwg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CODE_BITS-1:0] sample_code,
	input logic [WORD_BITS-1:0] dac_word,
	input logic                 falling
);

	// command word always carries the control bits over the code
	a_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dac_word == (CTRL_BITS | WORD_BITS'(sample_code))))
		else $error("dac_word does not match sample_code");

	// an empty result register never stalls the input side
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable(sample_code) && $stable(dac_word) && $stable(falling))
		else $error("result word changed while stalled");

endmodule

bind four_mode_dac_waveform_generator fmdwg_checker u_fmdwg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.sample_code (sample_code),
	.dac_word    (dac_word),
	.falling     (falling)
);
